### sv/mbde_pkg.sv
// Package with the shared constants, codes and types of the button debounce block.
`default_nettype none

package mbde_pkg;

	localparam int BUTTON_COUNT = 4;
	// Only four buttons have a line, an LED and an action code.
	localparam int BUTTON_LINES = (BUTTON_COUNT > 4) ? 4 : BUTTON_COUNT;
	localparam int LINE_COUNT   = 6;
	localparam int ACTIVE_LINES = 2 + BUTTON_LINES;
	localparam int TIME_W       = 32;
	localparam int MS_W         = 16;
	localparam int LED_W        = 4;
	localparam int ACTION_W     = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [MS_W-1:0] CHORD_RESET    = 16'd50;

	// The action code of an event equals the index of its line.
	localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SELECT  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PREV    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_PLAY    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_NEXT    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_MENU    = 3'd5;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_CHORD    = 2'd2;

	typedef struct packed {
		logic            enable;
		logic [MS_W-1:0] settle_ms;
		logic [MS_W-1:0] chord_window_ms;
	} cfg_t;

	// One poll with at least one event, as handed from the front to the back.
	typedef struct packed {
		logic [LINE_COUNT-1:0] emit;
		logic [LINE_COUNT-1:0] pressed;
		logic [TIME_W-1:0]     now_ms;
	} entry_t;

endpackage

`default_nettype wire

### sv/mbde_if.sv
// Handshake interfaces for the poll words and the event words.
`default_nettype none

interface mbde_poll_if import mbde_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [TIME_W-1:0]     now_ms;
	logic [LINE_COUNT-1:0] line_levels;

	modport source (output valid, output now_ms, output line_levels, input ready);
	modport sink   (input valid, input now_ms, input line_levels, output ready);
endinterface

interface mbde_event_if import mbde_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                pressed;
	logic [LED_W-1:0]    led_mask;
	logic                chord;
	logic                last;

	modport source (output valid, output action, output pressed, output led_mask,
		output chord, output last, input ready);
	modport sink   (input valid, input action, input pressed, input led_mask,
		input chord, input last, output ready);
endinterface

`default_nettype wire

### sv/mbde_front.sv
// Front end: debounces the six lines of each poll and marks the events it causes.
`default_nettype none

module mbde_front import mbde_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  take,
	input  wire logic [TIME_W-1:0]     now_ms,
	input  wire logic [LINE_COUNT-1:0] line_levels,
	output logic                       push,
	output entry_t                     entry
);

	logic [LINE_COUNT-1:0] released_q;
	logic [TIME_W-1:0]     change_q [LINE_COUNT];
	logic [LINE_COUNT-1:0] acc;
	logic [TIME_W-1:0]     elapsed [LINE_COUNT];

	// Each line is an independent lane: one wrapping subtract and one compare.
	always_comb begin
		for (int i = 0; i < LINE_COUNT; i++) begin
			elapsed[i] = now_ms - change_q[i];
			acc[i] = cfg.enable && (i < ACTIVE_LINES) && (line_levels[i] != released_q[i])
				&& (elapsed[i] >= {{(TIME_W-MS_W){1'b0}}, cfg.settle_ms});
		end
	end

	always_comb begin
		entry.emit    = acc;
		// A restart release is recorded but makes no event.
		entry.emit[0] = acc[0] && !line_levels[0];
		entry.pressed = ~line_levels;
		entry.now_ms  = now_ms;
		push          = take && (entry.emit != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= '1;
			for (int i = 0; i < LINE_COUNT; i++) change_q[i] <= '0;
		end else if (take) begin
			for (int i = 0; i < LINE_COUNT; i++) begin
				if (acc[i]) begin
					released_q[i] <= line_levels[i];
					change_q[i]   <= now_ms;
				end
			end
		end
	end

endmodule

`default_nettype wire

### sv/mbde_queue.sv
// Short queue of poll entries between the front end and the event sequencer.
`default_nettype none

module mbde_queue import mbde_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t wr_data,
	output logic        not_full,
	input  wire logic   pop,
	output logic        not_empty,
	output entry_t      rd_data
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign not_full  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### sv/mbde_back.sv
// Back end: issues the events of each poll in line order and tracks LEDs and the chord.
`default_nettype none

module mbde_back import mbde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        head_valid,
	input  wire entry_t      head,
	output logic             pop,
	mbde_event_if.source     evt
);

	logic [LINE_COUNT-1:0] done_q;
	logic [LED_W-1:0]      led_q;
	logic                  held1_q;
	logic                  held3_q;
	logic [TIME_W-1:0]     t1_q;
	logic [TIME_W-1:0]     t3_q;
	logic                  valid_q;
	logic [ACTION_W-1:0]   action_q;
	logic                  pressed_q;
	logic [LED_W-1:0]      led_mask_q;
	logic                  chord_q;
	logic                  last_q;

	logic [LINE_COUNT-1:0] remaining;
	logic [LINE_COUNT-1:0] low_bit;
	logic [ACTION_W-1:0]   sel;
	logic                  is_last;
	logic                  pr;
	logic                  fire;
	logic [LED_W-1:0]      led_n;
	logic                  held1_n;
	logic                  held3_n;
	logic [TIME_W-1:0]     t1_n;
	logic [TIME_W-1:0]     t3_n;
	logic [TIME_W-1:0]     dist_a;
	logic [TIME_W-1:0]     dist_b;
	logic [TIME_W-1:0]     span;
	logic                  chord_n;

	always_comb begin
		remaining = head.emit & ~done_q;
		low_bit   = remaining & (~remaining + 1'b1);
		is_last   = ((remaining & ~low_bit) == '0);
		sel       = '0;
		for (int i = LINE_COUNT - 1; i >= 0; i--) begin
			if (remaining[i]) sel = ACTION_W'(i);
		end
		pr   = head.pressed[sel];
		fire = head_valid && (!valid_q || evt.ready);
		pop  = fire && is_last;
	end

	// State after the selected event; the chord is judged on that state.
	always_comb begin
		led_n   = led_q;
		held1_n = held1_q;
		held3_n = held3_q;
		t1_n    = t1_q;
		t3_n    = t3_q;
		if (sel >= ACT_PREV) led_n[2'(sel - ACT_PREV)] = pr;
		case (sel)
			ACT_RESTART: begin
				led_n = '0;
			end
			ACT_PREV: begin
				held1_n = pr;
				if (pr) t1_n = head.now_ms;
			end
			ACT_NEXT: begin
				held3_n = pr;
				if (pr) t3_n = head.now_ms;
			end
			default: begin
			end
		endcase
		dist_a  = t1_n - t3_n;
		dist_b  = t3_n - t1_n;
		span    = dist_a[TIME_W-1] ? dist_b : dist_a;
		chord_n = held1_n && held3_n
			&& (span <= {{(TIME_W-MS_W){1'b0}}, cfg.chord_window_ms});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			led_q   <= '0;
			held1_q <= 1'b0;
			held3_q <= 1'b0;
			t1_q    <= '0;
			t3_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				done_q  <= is_last ? '0 : (done_q | low_bit);
				led_q   <= led_n;
				held1_q <= held1_n;
				held3_q <= held3_n;
				t1_q    <= t1_n;
				t3_q    <= t3_n;
				valid_q <= 1'b1;
			end else if (evt.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			action_q   <= sel;
			pressed_q  <= (sel == ACT_RESTART) ? 1'b1 : pr;
			led_mask_q <= led_n;
			chord_q    <= chord_n;
			last_q     <= is_last;
		end
	end

	assign evt.valid    = valid_q;
	assign evt.action   = action_q;
	assign evt.pressed  = pressed_q;
	assign evt.led_mask = led_mask_q;
	assign evt.chord    = chord_q;
	assign evt.last     = last_q;

endmodule

`default_nettype wire

### sv/multi_button_debounce_events_core.sv
// Top level of the multi-button debouncer with event output and its register port.
// Each poll word is taken while the two-entry queue has room, and a poll with no
// accepted event leaves no trace beyond its debounce state. Events leave through a
// one-word output register at up to one per cycle unless stalled, so a poll that causes
// n events (n up to six) holds the sequencer until all n are out; sustained throughput
// is set by that sequencer, one event per cycle, and the queue lets the front keep
// taking polls while earlier events wait to be taken. Registers: enable at byte 0, the
// debounce time at 4, chord_window_ms at 8; write them only while no poll is in flight.
`default_nettype none

module multi_button_debounce_events_core import mbde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	mbde_poll_if.sink              poll,
	mbde_event_if.source           evt
);

	cfg_t   cfg_q;
	logic   take;
	logic   push;
	logic   pop;
	logic   not_full;
	logic   not_empty;
	entry_t wr_entry;
	entry_t head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.settle_ms       <= DEBOUNCE_RESET;
			cfg_q.chord_window_ms <= CHORD_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ENABLE:   cfg_q.enable          <= pwdata[0];
				REG_DEBOUNCE: cfg_q.settle_ms       <= pwdata[MS_W-1:0];
				REG_CHORD:    cfg_q.chord_window_ms <= pwdata[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.enable};
			REG_DEBOUNCE: prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.settle_ms};
			REG_CHORD:    prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.chord_window_ms};
			default:      prdata = '0;
		endcase
	end

	assign poll.ready = not_full;
	assign take       = poll.valid && not_full;

	mbde_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.take        (take),
		.now_ms      (poll.now_ms),
		.line_levels (poll.line_levels),
		.push        (push),
		.entry       (wr_entry)
	);

	mbde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (wr_entry),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_data   (head)
	);

	mbde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.evt        (evt)
	);

endmodule

`default_nettype wire

### sv/mbde_checker.sv
// Port-level checks on the event words of the debouncer, bound to the top level.
`default_nettype none

module mbde_checker import mbde_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                evt_valid,
	input wire logic                evt_ready,
	input wire logic [ACTION_W-1:0] evt_action,
	input wire logic                evt_pressed,
	input wire logic [LED_W-1:0]    evt_led_mask,
	input wire logic                evt_chord,
	input wire logic                evt_last
);

	// A stalled event word must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_action)
			&& $stable(evt_pressed) && $stable(evt_led_mask)
			&& $stable(evt_chord) && $stable(evt_last))
		else $error("event word changed while stalled");

	// Only a restart press is reported, and it turns every LED off.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_action == ACT_RESTART |-> evt_pressed && evt_led_mask == '0)
		else $error("restart event with release or lit LED");

	// A button event leaves that button's LED matching the button.
	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_action >= ACT_PREV && evt_action <= ACT_MENU
			|-> evt_led_mask[2'(evt_action - ACT_PREV)] == evt_pressed)
		else $error("button LED does not follow its event");

	// Releasing either chord button ends the chord.
	a_chord: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_chord && (evt_action == ACT_PREV || evt_action == ACT_NEXT)
			|-> evt_pressed)
		else $error("chord reported on release of a chord button");

endmodule

bind multi_button_debounce_events_core mbde_checker u_mbde_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.evt_action   (evt.action),
	.evt_pressed  (evt.pressed),
	.evt_led_mask (evt.led_mask),
	.evt_chord    (evt.chord),
	.evt_last     (evt.last)
);

`default_nettype wire

### tb/sv/mbde_event_checker.sv
// Checker that predicts the event words of the button debouncer and compares them.
`timescale 1ns / 100ps

module mbde_event_checker import mbde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              pready,
	mbde_poll_if                   poll,
	mbde_event_if                  evt,
	output int                     mismatches,
	output int                     pending
);

	localparam int RESTART_LINE = 0;
	localparam int SELECT_LINE  = 1;
	localparam int B1_LINE      = 2;
	localparam int B2_LINE      = 3;
	localparam int B3_LINE      = 4;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                pressed;
		logic [LED_W-1:0]    led_mask;
		logic                chord;
		logic                last;
	} event_word_t;

	logic                  cfg_enable;
	logic [TIME_W-1:0]     debounce_span;
	logic [TIME_W-1:0]     window_span;
	logic [LINE_COUNT-1:0] released;
	logic [TIME_W-1:0]     changed_at [LINE_COUNT];
	logic [TIME_W-1:0]     b1_pressed_at;
	logic [TIME_W-1:0]     b3_pressed_at;
	logic [LED_W-1:0]      leds;
	event_word_t           awaited_events [$];
	event_word_t           seen;
	int                    bad_words = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic logic [ACTION_W-1:0] line_action(input int line);
		case (line)
			RESTART_LINE: return ACT_RESTART;
			SELECT_LINE:  return ACT_SELECT;
			B1_LINE:      return ACT_PREV;
			B2_LINE:      return ACT_PLAY;
			B3_LINE:      return ACT_NEXT;
			default:      return ACT_MENU;
		endcase
	endfunction

	// The chord distance is the shorter of the two wrapping differences.
	function automatic logic chord_held();
		logic [TIME_W-1:0] gap;
		if (released[B1_LINE] || released[B3_LINE])
			return 1'b0;
		gap = b1_pressed_at - b3_pressed_at;
		if (gap[TIME_W-1])
			gap = b3_pressed_at - b1_pressed_at;
		return gap <= window_span;
	endfunction

	task automatic debounce_poll(input logic [TIME_W-1:0] now,
		input logic [LINE_COUNT-1:0] lv);
		logic [TIME_W-1:0] elapsed;
		logic              press;
		int                made;
		event_word_t       w;
		made = 0;
		if (!cfg_enable)
			return;
		for (int line = 0; line < ACTIVE_LINES; line++) begin
			elapsed = now - changed_at[line];
			if (lv[line] != released[line] && elapsed >= debounce_span) begin
				released[line] = lv[line];
				changed_at[line] = now;
				press = !lv[line];
				if (line >= B1_LINE) begin
					leds[line - B1_LINE] = press;
					if (press && line == B1_LINE)
						b1_pressed_at = now;
					if (press && line == B3_LINE)
						b3_pressed_at = now;
				end
				// A restart press blanks the LEDs; its release makes no word.
				if (line == RESTART_LINE && press)
					leds = '0;
				if (line != RESTART_LINE || press) begin
					w.action = line_action(line);
					w.pressed = press;
					w.led_mask = leds;
					w.chord = chord_held();
					w.last = 1'b0;
					awaited_events.insert(awaited_events.size(), w);
					made++;
				end
			end
		end
		if (made > 0)
			awaited_events[awaited_events.size() - 1].last = 1'b1;
	endtask

	task automatic check_word(input event_word_t got);
		event_word_t want;
		if (awaited_events.size() == 0) begin
			bad_words++;
			if (bad_words <= REPORT_LIMIT)
				$display("%0t: unexpected event word: %0d/%0b/%h/%0b/%0b %s",
					$time, got.action, got.pressed, got.led_mask, got.chord, got.last,
					"(action/pressed/leds/chord/last)");
		end else begin
			want = awaited_events.pop_front();
			if (got.action !== want.action || got.pressed !== want.pressed ||
					got.led_mask !== want.led_mask || got.chord !== want.chord ||
					got.last !== want.last) begin
				bad_words++;
				if (bad_words <= REPORT_LIMIT)
					$display("%0t: expected %0d/%0b/%h/%0b/%0b got %0d/%0b/%h/%0b/%0b %s",
						$time, want.action, want.pressed, want.led_mask, want.chord,
						want.last, got.action, got.pressed, got.led_mask, got.chord,
						got.last, "(action/pressed/leds/chord/last)");
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_enable = 1'b0;
			debounce_span = {{(TIME_W-MS_W){1'b0}}, DEBOUNCE_RESET};
			window_span = {{(TIME_W-MS_W){1'b0}}, CHORD_RESET};
			released = '1;
			for (int i = 0; i < LINE_COUNT; i++)
				changed_at[i] = '0;
			b1_pressed_at = '0;
			b3_pressed_at = '0;
			leds = '0;
			awaited_events.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ENABLE:   cfg_enable = pwdata[0];
					REG_DEBOUNCE: debounce_span = {{(TIME_W-MS_W){1'b0}}, pwdata[MS_W-1:0]};
					REG_CHORD:    window_span = {{(TIME_W-MS_W){1'b0}}, pwdata[MS_W-1:0]};
					default: ;
				endcase
			end
			if (poll.valid && poll.ready)
				debounce_poll(poll.now_ms, poll.line_levels);
			if (evt.valid && evt.ready) begin
				seen.action = evt.action;
				seen.pressed = evt.pressed;
				seen.led_mask = evt.led_mask;
				seen.chord = evt.chord;
				seen.last = evt.last;
				check_word(seen);
			end
		end
		mismatches <= bad_words;
		pending <= awaited_events.size();
	end

endmodule

### tb/sv/multi_button_debounce_events_core_test.sv
// Top of the debouncer testbench: clock, reset, register writes, poll stimulus and verdict.
`timescale 1ns / 100ps

module multi_button_debounce_events_core_test;
	import mbde_pkg::*;

	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_MAX       = 16;
	localparam int B1_LINE        = 2;
	localparam int B3_LINE        = 4;
	localparam logic [LINE_COUNT-1:0] ONE_LINE = 1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int bad_words;
	int words_due;
	int stall_cycles = 0;
	logic calm = 1'b0;

	logic [TIME_W-1:0]     stamp;
	logic [LINE_COUNT-1:0] levels;
	logic [TIME_W-1:0]     debounce_now;
	logic [TIME_W-1:0]     window_now;
	logic [31:0]           pick_a;
	logic [31:0]           pick_b;

	mbde_poll_if  poll_ch ();
	mbde_event_if evt_ch ();

	multi_button_debounce_events_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.poll    (poll_ch),
		.evt     (evt_ch)
	);

	mbde_event_checker events_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.poll       (poll_ch),
		.evt        (evt_ch),
		.mismatches (bad_words),
		.pending    (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The event side stalls in bursts until the final phase.
	initial begin
		int run;
		logic hold;
		evt_ch.ready <= 1'b0;
		forever begin
			run = $urandom_range(1, IDLE_MAX);
			hold = !calm && ($urandom_range(0, 2) == 0);
			repeat (run) begin
				@(posedge clk);
				evt_ch.ready <= !hold;
			end
		end
	end

	always @(posedge clk) begin
		if ((poll_ch.valid && poll_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
				(psel && penable && pready))
			stall_cycles <= 0;
		else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	task automatic send_poll(input logic [TIME_W-1:0] at, input logic [LINE_COUNT-1:0] lv);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, IDLE_MAX);
			poll_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.now_ms <= at;
		poll_ch.line_levels <= lv;
		do @(posedge clk); while (!poll_ch.ready);
	endtask

	// Waits until every predicted word has come and a quiet poll has had time to finish.
	task automatic drain();
		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The bus is left idle after each write so that a following write starts cleanly.
	task automatic apb_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] win);
		apb_write(REG_DEBOUNCE, {{(DATA_W-MS_W){1'b0}}, deb});
		apb_write(REG_CHORD, {{(DATA_W-MS_W){1'b0}}, win});
		debounce_now = {{(TIME_W-MS_W){1'b0}}, deb};
		window_now = {{(TIME_W-MS_W){1'b0}}, win};
	endtask

	// Mostly steps past the debounce time, sometimes inside it, now and then anywhere.
	task automatic advance_clock();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			stamp = $urandom();
		else if (pick < 4)
			stamp = stamp + $urandom_range(0, debounce_now);
		else
			stamp = stamp + debounce_now + $urandom_range(0, 40);
	endtask

	task automatic random_polls(input int count);
		int done;
		int pick;
		logic [31:0] noise;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				noise = $urandom();
				levels = noise[LINE_COUNT-1:0];
				advance_clock();
				send_poll(stamp, levels);
				done++;
			end else if (pick < 3) begin
				// Buttons one and three released, then pressed one after the other.
				levels[B1_LINE] = 1'b1;
				levels[B3_LINE] = 1'b1;
				stamp = stamp + debounce_now + 1;
				send_poll(stamp, levels);
				levels[B1_LINE] = 1'b0;
				stamp = stamp + debounce_now + 1;
				send_poll(stamp, levels);
				levels[B3_LINE] = 1'b0;
				stamp = stamp + $urandom_range(0, 2 * window_now + 2);
				send_poll(stamp, levels);
				done += 3;
			end else begin
				levels = levels ^ (ONE_LINE << $urandom_range(0, LINE_COUNT - 1));
				if ($urandom_range(0, 1) == 0)
					levels = levels ^ (ONE_LINE << $urandom_range(0, LINE_COUNT - 1));
				advance_clock();
				send_poll(stamp, levels);
				done++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.now_ms <= '0;
		poll_ch.line_levels <= '1;
		debounce_now = {{(TIME_W-MS_W){1'b0}}, DEBOUNCE_RESET};
		window_now = {{(TIME_W-MS_W){1'b0}}, CHORD_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Still disabled after reset, so a full press makes no word.
		send_poll(32'd1000, 6'b000000);
		drain();
		apb_write(REG_ENABLE, 32'd1);

		// Too early after reset, then exactly at the debounce time.
		send_poll(32'd10, 6'b000000);
		send_poll(32'd49, 6'b000000);
		send_poll(32'd50, 6'b000000);
		send_poll(32'd60, 6'b111111);
		send_poll(32'd100, 6'b111111);
		// Chord inside the window, then a restart press with LEDs lit.
		send_poll(32'd200, 6'b111011);
		send_poll(32'd240, 6'b101011);
		send_poll(32'd300, 6'b101010);
		send_poll(32'd400, 6'b111111);
		// Chord exactly at the window edge, then just outside it.
		send_poll(32'd500, 6'b111011);
		send_poll(32'd550, 6'b101011);
		send_poll(32'd700, 6'b111111);
		send_poll(32'd800, 6'b111011);
		send_poll(32'd851, 6'b101011);
		send_poll(32'd1000, 6'b111111);
		// Press times on both sides of the time wrap.
		send_poll(32'hFFFF_FFE0, 6'b111011);
		send_poll(32'h0000_0010, 6'b101011);
		send_poll(32'hFFFF_FFFF, 6'b111111);
		send_poll(32'h0000_0000, 6'b000000);
		send_poll(32'h0000_0000, 6'b000000);
		stamp = '0;
		levels = '0;

		random_polls(60);
		drain();
		set_timing(16'd0, 16'd0);
		random_polls(60);
		drain();
		set_timing(16'hFFFF, 16'hFFFF);
		random_polls(50);
		drain();
		apb_write(REG_ENABLE, 32'd0);
		random_polls(20);
		drain();
		apb_write(REG_ENABLE, 32'd1);
		pick_a = $urandom_range(1, 200);
		pick_b = $urandom_range(0, 300);
		set_timing(pick_a[MS_W-1:0], pick_b[MS_W-1:0]);
		calm = 1'b1;
		random_polls(110);
		drain();

		if (bad_words == 0 && words_due == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
